// ----- rtl/kmm_pkg.sv -----
// ----------------------------------------------------------------------------
// kmm_pkg
// Shared types and constants for the k-mer minimizer target block.
// ----------------------------------------------------------------------------
package kmm_pkg;

    // Default sizes
    localparam int MAX_KMER_DEF  = 64;
    localparam int RANK_BITS_DEF = 16;

    // Field and register widths
    localparam int CHAR_W   = 8;
    localparam int TARGET_W = 17;
    localparam int KLEN_W   = 7;
    localparam int MLEN_W   = 5;
    localparam int RANK_W   = 16;
    localparam int CFG_DW   = 16;
    localparam int CFG_AW   = 2;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_KMER_LEN = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MIN_LEN  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_RANK_CNT = 2'd2;

    // Mix hash constants
    localparam logic [63:0] HASH_MUL1 = 64'd3935559000370003845;
    localparam logic [63:0] HASH_ADD1 = 64'd2691343689449507681;
    localparam logic [63:0] HASH_MUL2 = 64'd4768777513237032717;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALIGN,
        S_MUL,
        S_XS,
        S_MOD,
        S_OUT
    } t_state;

    // Map an ASCII character to a 2-bit code; valid is low for non-ACGT
    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } t_base;

    function automatic t_base base_decode(input logic [CHAR_W-1:0] c);
        t_base b;
        b.valid = 1'b1;
        case (c)
            8'h41, 8'h61: b.code = 2'd0;
            8'h43, 8'h63: b.code = 2'd1;
            8'h47, 8'h67: b.code = 2'd2;
            8'h54, 8'h74: b.code = 2'd3;
            default: begin
                b.code  = 2'd0;
                b.valid = 1'b0;
            end
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/kmm_in_if.sv -----
// ----------------------------------------------------------------------------
// kmm_in_if
// Input channel: one sequence character per item.
// ----------------------------------------------------------------------------
interface kmm_in_if;
    logic                        valid;
    logic                        ready;
    logic [kmm_pkg::CHAR_W-1:0]  base_char;
    logic                        last_base;

    modport source (output valid, output base_char, output last_base, input ready);
    modport sink   (input valid, input base_char, input last_base, output ready);
endinterface

// ----- rtl/kmm_out_if.sv -----
// ----------------------------------------------------------------------------
// kmm_out_if
// Output channel: one target per item.
// ----------------------------------------------------------------------------
interface kmm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kmm_pkg::TARGET_W-1:0] target;

    modport source (output valid, output target, input ready);
    modport sink   (input valid, input target, output ready);
endinterface

// ----- rtl/kmer_minimizer_target.sv -----
// ----------------------------------------------------------------------------
// kmer_minimizer_target
// Streaming k-mer partitioner: finds the largest canonical m-mer of each
// k-mer, hashes it and reduces it modulo the rank count.
// ----------------------------------------------------------------------------
//  channel | dir | payload              | handshake
//  i_in    | in  | base_char, last_base | valid/ready
//  o_out   | out | target (signed 17)   | valid/ready
//  cfg     | in  | i_cfg_idx, i_cfg_data| i_cfg_we, no wait
//
//  An item that yields no result, or an invalid k-mer, is handled in the idle state.
//  A hashed k-mer passes from acceptance to result through a window scan
//  over MAX_KMER positions, one align step, two multiplies on the shared
//  32x32 multiplier, six xorshift steps, a bit-serial modulo over the 64
//  hash bits and one output step.
//  Input is ready only when idle with the output register empty.
//  Synchronous active-low reset clears control state; the window needs none.
// ----------------------------------------------------------------------------
module kmer_minimizer_target #(
    parameter int MAX_KMER  = kmm_pkg::MAX_KMER_DEF,
    parameter int RANK_BITS = kmm_pkg::RANK_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    kmm_in_if.sink                     i_in,
    kmm_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [kmm_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [kmm_pkg::CFG_DW-1:0] i_cfg_data
);
    localparam int CW  = $clog2(MAX_KMER + 1);
    localparam int IW  = $clog2(MAX_KMER);
    localparam int NW  = (IW > 6) ? IW : 6;
    localparam int KX  = ((CW > kmm_pkg::KLEN_W) ? CW : kmm_pkg::KLEN_W) + 1;
    localparam int RCW = (RANK_BITS < kmm_pkg::RANK_W) ? RANK_BITS : kmm_pkg::RANK_W;
    localparam int WW  = 2 * MAX_KMER;

    // Configuration registers
    logic [kmm_pkg::KLEN_W-1:0] r_klen;
    logic [kmm_pkg::MLEN_W-1:0] r_mlen;
    logic [RCW-1:0]             r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= kmm_pkg::KLEN_W'(31);
            r_mlen <= kmm_pkg::MLEN_W'(15);
            r_rank <= RCW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kmm_pkg::REG_KMER_LEN: r_klen <= i_cfg_data[kmm_pkg::KLEN_W-1:0];
                kmm_pkg::REG_MIN_LEN:  r_mlen <= i_cfg_data[kmm_pkg::MLEN_W-1:0];
                kmm_pkg::REG_RANK_CNT: r_rank <= i_cfg_data[RCW-1:0];
                default: ;
            endcase
        end
    end

    // Effective k, clamped to 1..MAX_KMER
    logic [KX-1:0] k_ext, k_eff;
    logic [KX-1:0] m_ext;
    logic          no_cand;
    logic [KX:0]   thr_full;

    always_comb begin
        k_ext = KX'(r_klen);
        m_ext = KX'(r_mlen);
        if (k_ext == '0) k_eff = KX'(1);
        else if (k_ext > KX'(MAX_KMER)) k_eff = KX'(MAX_KMER);
        else k_eff = k_ext;
        no_cand  = (r_mlen == '0) || (m_ext > k_eff);
        thr_full = (KX+1)'(MAX_KMER) - (KX+1)'(k_eff) + (KX+1)'(m_ext) - (KX+1)'(1);
    end

    // State and datapath registers
    kmm_pkg::t_state r_state, n_state;
    logic [WW-1:0]   r_win, n_win, r_scan, n_scan;
    logic [CW-1:0]   r_seen, n_seen, r_run, n_run;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic [IW-1:0]   r_thr, n_thr;
    logic            r_none, n_none;
    logic            r_pass, n_pass;
    logic [61:0]     r_fwd, n_fwd, r_rc, n_rc, r_best, n_best;
    logic [63:0]     r_hash, n_hash, r_acc, n_acc;
    logic [RCW:0]    r_rem, n_rem;
    logic            r_ovalid, n_ovalid;
    logic signed [kmm_pkg::TARGET_W-1:0] r_target, n_target;

    // Shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] mul_k, mul_add;

    kmm_mul32 u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    always_comb begin
        mul_k   = r_pass ? kmm_pkg::HASH_MUL2 : kmm_pkg::HASH_MUL1;
        mul_add = r_pass ? 64'd0 : kmm_pkg::HASH_ADD1;
        case (r_cnt)
            NW'(1):  begin mul_a = r_hash[31:0];  mul_b = mul_k[63:32]; end
            NW'(2):  begin mul_a = r_hash[63:32]; mul_b = mul_k[31:0];  end
            default: begin mul_a = r_hash[31:0];  mul_b = mul_k[31:0];  end
        endcase
    end

    logic             accept;
    kmm_pkg::t_base   dec;
    logic [CW-1:0]    seen_inc, run_inc;
    logic [1:0]       sc;
    logic [61:0]      mask, fwd_nx, rc_nx, lesser;
    logic [RCW:0]     rem_sh;

    assign i_in.ready   = (r_state == kmm_pkg::S_IDLE) && !r_ovalid;
    assign accept       = i_in.valid && i_in.ready;
    assign o_out.valid  = r_ovalid;
    assign o_out.target = r_target;

    // Next state and datapath
    always_comb begin
        n_state  = r_state;
        n_win    = r_win;
        n_scan   = r_scan;
        n_seen   = r_seen;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_thr    = r_thr;
        n_none   = r_none;
        n_pass   = r_pass;
        n_fwd    = r_fwd;
        n_rc     = r_rc;
        n_best   = r_best;
        n_hash   = r_hash;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_target = r_target;
        n_ovalid = r_ovalid && !o_out.ready;

        dec      = kmm_pkg::base_decode(i_in.base_char);
        seen_inc = (r_seen < CW'(MAX_KMER)) ? r_seen + CW'(1) : r_seen;
        run_inc  = !dec.valid ? '0 : ((r_run < CW'(MAX_KMER)) ? r_run + CW'(1) : r_run);

        sc     = r_scan[WW-1 -: 2];
        mask   = (62'd1 << {r_mlen, 1'b0}) - 62'd1;
        fwd_nx = ({r_fwd[59:0], sc}) & mask;
        rc_nx  = (r_rc >> 2) | (62'(2'd3 - sc) << ({r_mlen, 1'b0} - 6'd2));
        lesser = (fwd_nx < rc_nx) ? fwd_nx : rc_nx;
        rem_sh = {r_rem[RCW-1:0], r_hash[63]};

        unique case (r_state)
            kmm_pkg::S_IDLE: begin
                if (accept) begin
                    n_win = {r_win[WW-3:0], dec.code};
                    n_seen = i_in.last_base ? '0 : seen_inc;
                    n_run  = i_in.last_base ? '0 : run_inc;
                    if (KX'(seen_inc) >= k_eff) begin
                        if (KX'(run_inc) < k_eff) begin
                            n_target = '1;
                            n_ovalid = 1'b1;
                        end else begin
                            n_scan  = {r_win[WW-3:0], dec.code};
                            n_cnt   = '0;
                            n_thr   = thr_full[IW-1:0];
                            n_none  = no_cand;
                            n_fwd   = '0;
                            n_rc    = '0;
                            n_best  = '0;
                            n_state = kmm_pkg::S_SCAN;
                        end
                    end
                end
            end
            kmm_pkg::S_SCAN: begin
                // Roll forward and reverse-complement m-mers, keep the max
                n_fwd  = fwd_nx;
                n_rc   = rc_nx;
                n_scan = {r_scan[WW-3:0], 2'b00};
                if (r_cnt[IW-1:0] >= r_thr && lesser > r_best) n_best = lesser;
                n_cnt = r_cnt + NW'(1);
                if (r_cnt == NW'(MAX_KMER - 1)) n_state = kmm_pkg::S_ALIGN;
            end
            kmm_pkg::S_ALIGN: begin
                // Left-align the winner in 64 bits, or zero when there is no candidate
                n_hash  = r_none ? 64'd0
                                 : ({2'b00, r_best} << (7'd64 - 7'({r_mlen, 1'b0})));
                n_pass  = 1'b0;
                n_cnt   = '0;
                n_state = kmm_pkg::S_MUL;
            end
            kmm_pkg::S_MUL: begin
                // Low 64 bits of hash * constant from three partial products, plus the add constant on the first pass
                n_cnt = r_cnt + NW'(1);
                case (r_cnt)
                    NW'(1):  n_acc = mul_p;
                    NW'(2):  n_acc = r_acc + {mul_p[31:0], 32'd0};
                    NW'(3):  n_acc = r_acc + {mul_p[31:0], 32'd0};
                    NW'(4): begin
                        n_hash  = r_acc + mul_add;
                        n_cnt   = '0;
                        n_state = kmm_pkg::S_XS;
                    end
                    default: ;
                endcase
            end
            kmm_pkg::S_XS: begin
                // One xorshift step per cycle
                n_cnt = r_cnt + NW'(1);
                case ({r_pass, r_cnt[1:0]})
                    3'b000:  n_hash = r_hash ^ (r_hash >> 21);
                    3'b001:  n_hash = r_hash ^ (r_hash << 37);
                    3'b010:  n_hash = r_hash ^ (r_hash >> 4);
                    3'b100:  n_hash = r_hash ^ (r_hash << 20);
                    3'b101:  n_hash = r_hash ^ (r_hash >> 41);
                    default: n_hash = r_hash ^ (r_hash << 5);
                endcase
                if (r_cnt == NW'(2)) begin
                    n_cnt = '0;
                    if (r_pass) begin
                        n_rem   = '0;
                        n_state = kmm_pkg::S_MOD;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = kmm_pkg::S_MUL;
                    end
                end
            end
            kmm_pkg::S_MOD: begin
                // Restoring remainder, one hash bit per cycle
                n_hash = {r_hash[62:0], 1'b0};
                n_rem  = (rem_sh >= (RCW+1)'(r_rank)) ? rem_sh - (RCW+1)'(r_rank) : rem_sh;
                n_cnt  = r_cnt + NW'(1);
                if (r_cnt == NW'(63)) n_state = kmm_pkg::S_OUT;
            end
            kmm_pkg::S_OUT: begin
                n_target = (r_rank == '0) ? '0
                         : $signed({(kmm_pkg::TARGET_W - RCW)'(0), r_rem[RCW-1:0]});
                n_ovalid = 1'b1;
                n_state  = kmm_pkg::S_IDLE;
            end
            default: n_state = kmm_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kmm_pkg::S_IDLE;
            r_seen   <= '0;
            r_run    <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_pass   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_run    <= n_run;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_pass   <= n_pass;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_win    <= n_win;
        r_scan   <= n_scan;
        r_thr    <= n_thr;
        r_none   <= n_none;
        r_fwd    <= n_fwd;
        r_rc     <= n_rc;
        r_best   <= n_best;
        r_hash   <= n_hash;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_target <= n_target;
    end
endmodule

// ----- rtl/kmm_mul32.sv -----
// ----------------------------------------------------------------------------
// kmm_mul32
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module kmm_mul32 (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule

// ----- rtl/kmm_checker.sv -----
// ----------------------------------------------------------------------------
// kmm_checker
// Port-level checks for the k-mer minimizer target block.
// ----------------------------------------------------------------------------
module kmm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [kmm_pkg::TARGET_W-1:0] i_target
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_target))
        else $error("result dropped or changed while stalled");

    // Accept no item while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid)
        else $error("item accepted with a result pending");

    // Negative targets are only the invalid marker
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_target[kmm_pkg::TARGET_W-1] |-> (&i_target))
        else $error("negative target other than -1");

    // A new result follows an accepted item
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !i_in_ready || $past(i_in_valid && i_in_ready))
        else $error("result without an accepted item");
endmodule

bind kmer_minimizer_target kmm_checker u_kmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_target    (o_out.target)
);
